@@ hw/rtl/bab_pkg.sv @@
`timescale 1ns / 1ps

package bab_pkg;

  localparam int POOL_BYTES      = 4096;
  localparam int MIN_BLOCK_BYTES = 64;
  localparam int DEF_TREE_LEVELS = 7;
  localparam int POOL_LOG2       = $clog2(POOL_BYTES);

  localparam int SIZE_W = 13;
  localparam int OFF_W  = 12;
  localparam int STAT_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 2'd2;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] req_size;
    logic [OFF_W-1:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  alloc_offset;
  } resp_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_UP,
    RD_BUDDY
  } rd_sel_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_UP_RD,
    ST_UP_CHK,
    ST_FILL,
    ST_FUP_RD,
    ST_FUP_CHK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    scan_next;
    logic    found;
    logic    no_space;
    logic    up_init;
    logic    up_mark;
    logic    fill_init;
    logic    fill_step;
    logic    fup_mark;
    logic    clr_step;
    logic    out_load;
    rd_sel_e rd_sel;
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic is_free;
    logic rd_used;
    logic scan_last;
    logic up_zero;
    logic fill_last;
    logic node_root;
    logic clr_last;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/bab_chan_if.sv @@
`timescale 1ns / 1ps

interface bab_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/buddy_allocator_bitmap_tree_top.sv @@
// channel | role | payload                         | beat when
// req     | sink | op, req_size, block_offset      | valid && ready
// resp    | src  | status, alloc_offset            | valid && ready
//
// After reset a clearing pass writes 2^TREE_LEVELS bitmap entries, one a
// cycle (128 entries by default); req.ready stays low meanwhile.
// One request at a time; the used-bit tree sits in a 1-bit RAM with one write
// port and one registered read port. Allocate scans the level's nodes, marks
// the free node's unmarked ancestors used and fills its subtree; free clears
// the subtree and walks up, clearing parents while the buddy is free.
// A finished beat waits in the output register; the next request is taken
// meanwhile and stalls only at its own result.
`timescale 1ns / 1ps

module buddy_allocator_bitmap_tree_top #(
  parameter int TREE_LEVELS = bab_pkg::DEF_TREE_LEVELS
) (
  input logic        clk,
  input logic        rst,
  bab_chan_if.sink   req,
  bab_chan_if.source resp
);
  import bab_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  resp_t resp_data;
  logic  resp_valid;

  bab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bab_dp #(
    .TREE_LEVELS (TREE_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req_data   (req.data),
    .resp_data  (resp_data),
    .resp_valid (resp_valid),
    .resp_ready (resp.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign resp.valid = resp_valid;
  assign resp.data  = resp_data;

endmodule

@@ hw/rtl/bab_ram.sv @@
`timescale 1ns / 1ps

module bab_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/bab_ctrl.sv @@
`timescale 1ns / 1ps

module bab_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bab_pkg::sts_t sts,
  output bab_pkg::cmd_t cmd
);
  import bab_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_SCAN;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (sts.too_large) begin
          state_next = ST_RESP;
        end else if (sts.is_free) begin
          cmd.fill_init = 1'b1;
          state_next    = ST_FILL;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd.rd_sel = RD_SCAN;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!sts.rd_used) begin
          cmd.found   = 1'b1;
          cmd.up_init = 1'b1;
          state_next  = ST_UP_RD;
        end else if (sts.scan_last) begin
          cmd.no_space = 1'b1;
          state_next   = ST_RESP;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_UP_RD: begin
        cmd.rd_sel = RD_UP;
        if (sts.up_zero) begin
          cmd.fill_init = 1'b1;
          state_next    = ST_FILL;
        end else begin
          state_next = ST_UP_CHK;
        end
      end
      ST_UP_CHK: begin
        if (sts.rd_used) begin
          cmd.fill_init = 1'b1;
          state_next    = ST_FILL;
        end else begin
          cmd.up_mark = 1'b1;
          state_next  = ST_UP_RD;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_next = sts.is_free ? ST_FUP_RD : ST_RESP;
        end
      end
      ST_FUP_RD: begin
        cmd.rd_sel = RD_BUDDY;
        state_next = sts.node_root ? ST_RESP : ST_FUP_CHK;
      end
      ST_FUP_CHK: begin
        if (sts.rd_used) begin
          state_next = ST_RESP;
        end else begin
          cmd.fup_mark = 1'b1;
          state_next   = ST_FUP_RD;
        end
      end
      ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ hw/rtl/bab_dp.sv @@
`timescale 1ns / 1ps

module bab_dp #(
  parameter int TREE_LEVELS = bab_pkg::DEF_TREE_LEVELS
) (
  input  logic           clk,
  input  logic           rst,
  input  bab_pkg::req_t  req_data,
  output bab_pkg::resp_t resp_data,
  output logic           resp_valid,
  input  logic           resp_ready,
  input  bab_pkg::cmd_t  cmd,
  output bab_pkg::sts_t  sts
);
  import bab_pkg::*;

  localparam int AW         = TREE_LEVELS;
  localparam int NW         = TREE_LEVELS + 1;
  localparam int NODE_COUNT = 1 << TREE_LEVELS;
  localparam int LW         = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
  localparam int FW         = NW + POOL_LOG2 + OFF_W;

  logic              op;
  logic              too_large;
  logic [LW-1:0]     level;
  logic [NW-1:0]     node;
  logic [NW-1:0]     up;
  logic [NW-1:0]     cur;
  logic [NW-1:0]     row_start;
  logic [NW-1:0]     row_end;
  logic [AW-1:0]     clr_cnt;
  logic [STAT_W-1:0] res_status;
  logic [OFF_W-1:0]  res_offset;

  int            lvl_sum;
  logic [LW-1:0] lvl_c;
  logic [NW-1:0] first_c;
  logic [FW-1:0] free_sh;
  logic [NW-1:0] free_node_c;
  logic          too_large_c;

  logic [NW-1:0]    first_q;
  logic [NW-1:0]    k_q;
  logic [FW-1:0]    alloc_sh;
  logic [NW-1:0]    buddy;
  logic [NW-1:0]    cur_inc;
  logic             row_done;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_rdata;

  // level = count of levels below the root whose block still fits the size
  always_comb begin
    lvl_sum = 0;
    for (int l = 1; l < TREE_LEVELS; l++) begin
      if ((POOL_BYTES >> l) >= MIN_BLOCK_BYTES &&
          int'(req_data.req_size) <= (POOL_BYTES >> l)) begin
        lvl_sum = lvl_sum + 1;
      end
    end
    lvl_c = LW'(lvl_sum);
  end

  assign too_large_c = int'(req_data.req_size) > POOL_BYTES;
  assign first_c     = NW'(1) << lvl_c;
  assign free_sh     = (FW'(req_data.block_offset) << lvl_c) >> POOL_LOG2;
  assign free_node_c = first_c | (free_sh[NW-1:0] & (first_c - NW'(1)));

  assign first_q  = NW'(1) << level;
  assign k_q      = node & (first_q - NW'(1));
  assign alloc_sh = (FW'(k_q) << POOL_LOG2) >> level;
  assign buddy    = node ^ NW'(1);
  assign cur_inc  = cur + NW'(1);
  assign row_done = cur_inc == row_end;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op         <= req_data.op;
      too_large  <= too_large_c;
      level      <= lvl_c;
      node       <= (req_data.op == OP_FREE) ? free_node_c : first_c;
      res_status <= too_large_c ? STAT_TOO_LARGE : STAT_OK;
      res_offset <= '0;
    end
    if (cmd.scan_next) begin
      node <= node + NW'(1);
    end
    if (cmd.found) begin
      res_offset <= alloc_sh[OFF_W-1:0];
    end
    if (cmd.no_space) begin
      res_status <= STAT_NO_SPACE;
    end
    if (cmd.up_init) begin
      up <= node >> 1;
    end
    if (cmd.up_mark) begin
      up <= up >> 1;
    end
    if (cmd.fup_mark) begin
      node <= node >> 1;
    end
    if (cmd.fill_init) begin
      cur       <= node;
      row_start <= node;
      row_end   <= node + NW'(1);
    end
    if (cmd.fill_step) begin
      if (row_done) begin
        cur       <= row_start << 1;
        row_start <= row_start << 1;
        row_end   <= row_end << 1;
      end else begin
        cur <= cur_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      resp_data.status       <= res_status;
      resp_data.alloc_offset <= res_offset;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = node[AW-1:0];
    mem_wdata = 1'b0;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
    end else if (cmd.up_mark) begin
      mem_we    = 1'b1;
      mem_waddr = up[AW-1:0];
      mem_wdata = 1'b1;
    end else if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = cur[AW-1:0];
      mem_wdata = (op == OP_ALLOC);
    end else if (cmd.fup_mark) begin
      mem_we    = 1'b1;
      mem_waddr = node[AW:1];
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_SCAN:  mem_raddr = node[AW-1:0];
      RD_UP:    mem_raddr = up[AW-1:0];
      RD_BUDDY: mem_raddr = buddy[AW-1:0];
      default:  mem_raddr = node[AW-1:0];
    endcase
  end

  bab_ram #(
    .WIDTH (1),
    .DEPTH (NODE_COUNT)
  ) u_bits (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    sts.too_large = too_large;
    sts.is_free   = (op == OP_FREE);
    sts.rd_used   = mem_rdata;
    sts.scan_last = (node + NW'(1)) == (first_q << 1);
    sts.up_zero   = (up == '0);
    sts.fill_last = row_done && row_start[TREE_LEVELS-1];
    sts.node_root = (node[NW-1:1] == '0);
    sts.clr_last  = (clr_cnt == AW'(NODE_COUNT - 1));
    sts.out_busy  = resp_valid && !resp_ready;
  end

endmodule

@@ hw/rtl/bab_checker.sv @@
`timescale 1ns / 1ps

module bab_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       resp_valid,
  input logic                       resp_ready,
  input logic [bab_pkg::STAT_W-1:0] resp_status,
  input logic [bab_pkg::OFF_W-1:0]  resp_alloc_offset
);
  import bab_pkg::*;

  localparam logic [OFF_W-1:0] ALIGN_MASK = OFF_W'(MIN_BLOCK_BYTES - 1);

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("resp beat dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during bitmap clear");

  a_err_offset: assert property (@(posedge clk) disable iff (rst)
    resp_valid && resp_status != STAT_OK |-> resp_alloc_offset == '0)
    else $error("nonzero offset on error status");

  a_align: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> (resp_alloc_offset & ALIGN_MASK) == '0)
    else $error("offset not aligned to minimum block");

endmodule

bind buddy_allocator_bitmap_tree_top bab_checker u_bab_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .resp_valid        (resp.valid),
  .resp_ready        (resp.ready),
  .resp_status       (resp.data.status),
  .resp_alloc_offset (resp.data.alloc_offset)
);

@@ dv/buddy_allocator_bitmap_tree_top_test.sv @@
`timescale 1ns / 1ps

module buddy_allocator_bitmap_tree_top_test;
  import bab_pkg::*;

  localparam int LEVELS     = DEF_TREE_LEVELS;
  localparam int NODES      = 1 << LEVELS;
  localparam int LEAF       = LEVELS - 1;
  localparam int RAND_REQS  = 1000;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_AT    = 200;
  localparam int HOLD_LEN   = 1500;
  localparam int DRAIN      = 300;

  typedef enum int {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bab_chan_if #(.payload_t(req_t))  req ();
  bab_chan_if #(.payload_t(resp_t)) resp ();

  buddy_allocator_bitmap_tree_top u_dut (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  req_t             pending_reqs[$];
  resp_t            expected_resps[$];
  logic [NODES-1:0] gen_used;
  logic [NODES-1:0] dut_used;
  int               live_off[$];
  int               live_size[$];
  int               total_reqs;
  int               accepted_count;
  int               resp_count;
  int               mismatch_count;
  int               burst_left;
  int               gap_left;
  int               hold_left;
  bit               held_off;
  int               stall_tick;
  sink_mode_e       stall_mode;
  int               idle_cycles;
  resp_t            want;

  function automatic void set_subtree(inout logic [NODES-1:0] used, input int node,
                                      input int lvl, input logic v);
    for (int d = 0; lvl + d <= LEAF; d++) begin
      for (int n = node << d; n < ((node + 1) << d) && n < NODES; n++) begin
        used[n] = v;
      end
    end
  endfunction

  function automatic resp_t serve_request(inout logic [NODES-1:0] used, input req_t r);
    resp_t       rsp;
    int          lvl;
    int unsigned half;
    int unsigned blk;
    int          node;
    int          up;
    rsp = '0;
    if (r.req_size > POOL_BYTES) begin
      rsp.status = STAT_TOO_LARGE;
      return rsp;
    end
    lvl  = 0;
    half = POOL_BYTES / 2;
    while (lvl < LEAF && half >= MIN_BLOCK_BYTES && r.req_size <= half) begin
      lvl++;
      half >>= 1;
    end
    blk = POOL_BYTES >> lvl;
    if (r.op == OP_ALLOC) begin
      rsp.status = STAT_NO_SPACE;
      for (int k = 0; k < (1 << lvl); k++) begin
        node = (1 << lvl) + k;
        if (!used[node]) begin
          up = node >> 1;
          while (up >= 1 && !used[up]) begin
            used[up] = 1'b1;
            up >>= 1;
          end
          set_subtree(used, node, lvl, 1'b1);
          rsp.status       = STAT_OK;
          rsp.alloc_offset = OFF_W'(k * blk);
          return rsp;
        end
      end
    end else begin
      node = (1 << lvl) + ((int'(r.block_offset) / blk) & ((1 << lvl) - 1));
      set_subtree(used, node, lvl, 1'b0);
      while (node > 1 && !used[node ^ 1]) begin
        node >>= 1;
        used[node] = 1'b0;
      end
    end
    return rsp;
  endfunction

  // queue a request and track live blocks on a shadow bitmap
  task automatic add_request(input logic op, input int size, input int off);
    req_t  r;
    resp_t rsp;
    r.op           = op;
    r.req_size     = SIZE_W'(size);
    r.block_offset = OFF_W'(off);
    rsp = serve_request(gen_used, r);
    if (op == OP_ALLOC && rsp.status == STAT_OK) begin
      live_off.push_back(int'(rsp.alloc_offset));
      live_size.push_back(size);
    end
    pending_reqs.push_back(r);
  endtask

  task automatic build_stimulus();
    int roll;
    int lvl;
    int blk;
    int size;
    int idx;
    gen_used = '0;
    add_request(OP_ALLOC, 0, 0);
    add_request(OP_ALLOC, 1, 4095);
    add_request(OP_ALLOC, 64, 0);
    add_request(OP_ALLOC, 65, 0);
    add_request(OP_ALLOC, 4096, 0);
    add_request(OP_ALLOC, 4097, 0);
    add_request(OP_ALLOC, 8191, 4095);
    add_request(OP_FREE, 8191, 4095);
    add_request(OP_FREE, 64, 65);
    add_request(OP_FREE, 64, 0);
    add_request(OP_FREE, 64, 128);
    add_request(OP_FREE, 128, 256);
    add_request(OP_FREE, 64, 4095);
    add_request(OP_ALLOC, 4096, 1234);
    add_request(OP_ALLOC, 2048, 0);
    add_request(OP_FREE, 4096, 0);
    add_request(OP_ALLOC, 2048, 0);
    add_request(OP_ALLOC, 2048, 0);
    add_request(OP_ALLOC, 2049, 0);
    add_request(OP_ALLOC, 2048, 0);
    add_request(OP_FREE, 2048, 3048);
    add_request(OP_FREE, 2048, 0);
    add_request(OP_ALLOC, 2049, 2730);
    add_request(OP_FREE, 4096, 4095);
    add_request(OP_FREE, 0, 4095);
    live_off.delete();
    live_size.delete();

    for (int i = 0; i < RAND_REQS; i++) begin
      roll = $urandom_range(99);
      if (live_off.size() > 24) roll = roll + 20;
      if (roll < 45 || (roll < 85 && live_off.size() == 0)) begin
        lvl  = ($urandom_range(99) < 70) ? $urandom_range(LEAF, 3) : $urandom_range(2, 0);
        blk  = POOL_BYTES >> lvl;
        size = (lvl == LEAF) ? $urandom_range(blk) : $urandom_range(blk, blk / 2 + 1);
        add_request(OP_ALLOC, size, $urandom_range(4095));
      end else if (roll < 85 || roll >= 100) begin
        idx = $urandom_range(live_off.size() - 1);
        add_request(OP_FREE, live_size[idx], live_off[idx]);
        live_off.delete(idx);
        live_size.delete(idx);
      end else begin
        size = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(4096);
        add_request(logic'($urandom_range(1)), size, $urandom_range(4095));
      end
    end
    total_reqs = pending_reqs.size();
  endtask

  initial begin
    req.valid      = 1'b0;
    req.data       = '0;
    resp.ready     = 1'b0;
    dut_used       = '0;
    accepted_count = 0;
    resp_count     = 0;
    mismatch_count = 0;
    burst_left     = 0;
    gap_left       = 0;
    hold_left      = 0;
    held_off       = 1'b0;
    stall_tick     = 0;
    stall_mode     = SINK_OPEN;
    idle_cycles    = 0;
    build_stimulus();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (accepted_count != total_reqs) @(posedge clk);
    while (expected_resps.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        expected_resps.push_back(serve_request(dut_used, req.data));
        accepted_count++;
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req.data  <= pending_reqs.pop_front();
          req.valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(40, 1);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off once, else random sink patterns; the hold-off backs the block up into its request port
  always @(posedge clk) begin
    if (rst) begin
      resp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      resp.ready <= 1'b0;
    end else if (!held_off && resp_count >= HOLD_AT) begin
      held_off = 1'b1;
      hold_left = HOLD_LEN;
      resp.ready <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = sink_mode_e'($urandom_range(3));
      case (stall_mode)
        SINK_OPEN:   resp.ready <= 1'b1;
        SINK_COIN:   resp.ready <= logic'($urandom_range(1));
        SINK_SPARSE: resp.ready <= ($urandom_range(3) == 0);
        default:     resp.ready <= ((stall_tick % 8) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && resp.valid && resp.ready) begin
      resp_count++;
      if (expected_resps.size() == 0) begin
        $error("unexpected beat: status %0d alloc_offset %0d",
               resp.data.status, resp.data.alloc_offset);
        mismatch_count++;
      end else begin
        want = expected_resps.pop_front();
        if (resp.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, resp.data.status);
          mismatch_count++;
        end
        if (resp.data.alloc_offset !== want.alloc_offset) begin
          $error("alloc_offset: expected %0d, got %0d",
                 want.alloc_offset, resp.data.alloc_offset);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (resp.valid && resp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
